// File: hdl/pid_controller_anti_windup_core_assert.svh
// Assertion macros used by the PID core controller module.
`ifndef PID_CONTROLLER_ANTI_WINDUP_CORE_ASSERT_SVH
`define PID_CONTROLLER_ANTI_WINDUP_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PIDAW_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pid core: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define PIDAW_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pid core: next-cycle check failed");

`endif

// File: hdl/pidaw_pkg.sv
`timescale 1ns / 1ps

package pidaw_pkg;

    // Fixed widths of the configuration and port words
    localparam int GAIN_W     = 32;
    localparam int RATE_W     = 31;
    localparam int WORD_W     = 32;
    localparam int CFG_ADDR_W = 5;
    localparam int REG_IDX_W  = 3;

    // Input opcodes
    localparam logic [1:0] OPC_MEASURE = 2'd0;
    localparam logic [1:0] OPC_DERIV   = 2'd1;
    localparam logic [1:0] OPC_LIMIT   = 2'd2;

    // Register indexes (byte address is 4 times the index)
    localparam logic [REG_IDX_W-1:0] REG_PROP_GAIN       = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_INTEGRAL_GAIN   = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_DERIV_GAIN      = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_SAMPLE_RATE     = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_SAMPLE_PERIOD   = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_TARGET_SETPOINT = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_DERIVATIVE_MODE = 3'd6;

    // Reset values
    localparam logic [RATE_W-1:0] RATE_RESET   = 31'd65536;
    localparam logic [RATE_W-1:0] PERIOD_RESET = 31'd65536;

    typedef struct packed {
        logic signed [GAIN_W-1:0] prop_gain;
        logic signed [GAIN_W-1:0] integral_gain;
        logic signed [GAIN_W-1:0] deriv_gain;
        logic [RATE_W-1:0]        sample_rate;
        logic [RATE_W-1:0]        sample_period;
        logic signed [GAIN_W-1:0] target_setpoint;
        logic                     derivative_mode;
    } cfg_t;

    // Multiplier operand pairs
    typedef enum logic [2:0] {
        MS_ERR_PERIOD = 3'd0,
        MS_ERR_KP     = 3'd1,
        MS_INT_KI     = 3'd2,
        MS_DER_KD     = 3'd3,
        MS_T_RATE     = 3'd4,
        MS_T_KD       = 3'd5
    } mul_sel_t;

    // Datapath register updates
    typedef enum logic [3:0] {
        DP_NONE       = 4'd0,
        DP_LOAD       = 4'd1,
        DP_ERR_UPDATE = 4'd2,
        DP_DERIV_LOAD = 4'd3,
        DP_FAULT      = 4'd4,
        DP_INT_ACC    = 4'd5,
        DP_NUM_LOAD   = 4'd6,
        DP_INT_DIV    = 4'd7,
        DP_P_STORE    = 4'd8,
        DP_I_STORE    = 4'd9,
        DP_D_STORE    = 4'd10,
        DP_DIFF_LOAD  = 4'd11,
        DP_T_STORE    = 4'd12,
        DP_OUT_LOAD   = 4'd13
    } dp_op_t;

    typedef struct packed {
        dp_op_t   dp_op;
        logic     mul_start;
        mul_sel_t mul_sel;
        logic     div_start;
    } ctrl_cmd_t;

    typedef struct packed {
        logic [1:0] opcode;
        logic       ki_zero;
        logic       deriv_mode;
        logic       mul_done;
        logic       div_done;
    } ctrl_stat_t;

endpackage

// File: hdl/pidaw_mul.sv
`timescale 1ns / 1ps

// Fractional multiply: floor((a*b) >> FRAC_BITS), saturated to DATA_WIDTH.
// One DATA_WIDTH x 16 partial product per cycle, then a rounding stage.
module pidaw_mul #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic signed [DATA_WIDTH-1:0] a,
    input  logic signed [pidaw_pkg::GAIN_W-1:0] b,
    output logic [DATA_WIDTH-1:0]        result,
    output logic                         done
);

    localparam int DW = DATA_WIDTH;
    localparam int BW = pidaw_pkg::GAIN_W;
    localparam int HW = BW / 2;
    localparam int PW = DW + BW;
    localparam int QW = PW - FRAC_BITS + 1;

    typedef enum logic [3:0] {
        PH_IDLE  = 4'b0001,
        PH_LOW   = 4'b0010,
        PH_HIGH  = 4'b0100,
        PH_ROUND = 4'b1000
    } phase_t;

    phase_t           phase_reg, phase_next;
    logic [DW-1:0]    amag_reg;
    logic [BW-1:0]    bmag_reg;
    logic             neg_reg;
    logic [PW-1:0]    acc_reg;
    logic [DW-1:0]    res_reg;
    logic             done_reg;

    logic [HW-1:0]    digit;
    logic [DW+HW-1:0] pp;
    logic [QW-1:0]    qr;
    logic [DW-1:0]    qlow;
    logic             ovf;
    logic [DW-1:0]    res_next;

    assign digit = (phase_reg == PH_LOW) ? bmag_reg[HW-1:0] : bmag_reg[BW-1:HW];
    assign pp    = amag_reg * digit;

    // round toward minus infinity: bump the magnitude of a negative result
    assign qr   = {1'b0, acc_reg[PW-1:FRAC_BITS]}
                + QW'(neg_reg && (|acc_reg[FRAC_BITS-1:0]));
    assign qlow = qr[DW-1:0];

    always_comb
    begin
        if (neg_reg)
            ovf = (|qr[QW-1:DW]) || (qr[DW-1] && (|qr[DW-2:0]));
        else
            ovf = |qr[QW-1:DW-1];
        if (ovf)
            res_next = neg_reg ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
        else
            res_next = neg_reg ? (~qlow + 1'b1) : qlow;
    end

    always_comb
    begin
        phase_next = phase_reg;
        unique case (phase_reg)
            PH_IDLE:  if (start) phase_next = PH_LOW;
            PH_LOW:   phase_next = PH_HIGH;
            PH_HIGH:  phase_next = PH_ROUND;
            PH_ROUND: phase_next = PH_IDLE;
            default:  phase_next = PH_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            done_reg  <= (phase_reg == PH_ROUND);
        end
    end

    always_ff @(posedge clk)
    begin
        if (phase_reg == PH_IDLE && start)
        begin
            amag_reg <= a[DW-1] ? (~a + 1'b1) : a;
            bmag_reg <= b[BW-1] ? (~b + 1'b1) : b;
            neg_reg  <= a[DW-1] ^ b[BW-1];
        end
        if (phase_reg == PH_LOW)
            acc_reg <= PW'(pp);
        if (phase_reg == PH_HIGH)
            acc_reg <= acc_reg + {pp, {HW{1'b0}}};
        if (phase_reg == PH_ROUND)
            res_reg <= res_next;
    end

    assign result = res_reg;
    assign done   = done_reg;

endmodule

// File: hdl/pidaw_div.sv
`timescale 1ns / 1ps

// Restoring divider: (num << FRAC_BITS) / den truncated toward zero,
// saturated to DATA_WIDTH. One quotient bit per cycle.
module pidaw_div #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic signed [DATA_WIDTH-1:0] num,
    input  logic signed [pidaw_pkg::GAIN_W-1:0] den,
    output logic [DATA_WIDTH-1:0]        result,
    output logic                         done
);

    localparam int DW = DATA_WIDTH;
    localparam int RW = pidaw_pkg::GAIN_W;
    localparam int NW = DW + FRAC_BITS;
    localparam int CW = $clog2(NW + 1);

    typedef enum logic [2:0] {
        DV_IDLE = 3'b001,
        DV_RUN  = 3'b010,
        DV_SAT  = 3'b100
    } dv_state_t;

    dv_state_t     state_reg, state_next;
    logic [CW-1:0] count_reg;
    logic [NW-1:0] shreg_reg;
    logic [RW-1:0] rem_reg;
    logic [RW-1:0] dmag_reg;
    logic          neg_reg;
    logic [DW-1:0] res_reg;
    logic          done_reg;

    logic [RW:0]   trial;
    logic [RW:0]   diff;
    logic          ge;
    logic [DW-1:0] qlow;
    logic          ovf;
    logic [DW-1:0] res_next;

    assign trial = {rem_reg, shreg_reg[NW-1]};
    assign diff  = trial - {1'b0, dmag_reg};
    assign ge    = (trial >= {1'b0, dmag_reg});
    assign qlow  = shreg_reg[DW-1:0];

    always_comb
    begin
        if (neg_reg)
            ovf = (|shreg_reg[NW-1:DW]) || (shreg_reg[DW-1] && (|shreg_reg[DW-2:0]));
        else
            ovf = |shreg_reg[NW-1:DW-1];
        if (ovf)
            res_next = neg_reg ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
        else
            res_next = neg_reg ? (~qlow + 1'b1) : qlow;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            DV_IDLE: if (start) state_next = DV_RUN;
            DV_RUN:  if (count_reg == CW'(1)) state_next = DV_SAT;
            DV_SAT:  state_next = DV_IDLE;
            default: state_next = DV_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= DV_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == DV_SAT);
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == DV_IDLE && start)
        begin
            shreg_reg <= {(num[DW-1] ? (~num + 1'b1) : num), {FRAC_BITS{1'b0}}};
            dmag_reg  <= den[RW-1] ? (~den + 1'b1) : den;
            neg_reg   <= num[DW-1] ^ den[RW-1];
            rem_reg   <= '0;
            count_reg <= CW'(NW);
        end
        if (state_reg == DV_RUN)
        begin
            rem_reg   <= ge ? diff[RW-1:0] : trial[RW-1:0];
            shreg_reg <= {shreg_reg[NW-2:0], ge};
            count_reg <= count_reg - 1'b1;
        end
        if (state_reg == DV_SAT)
            res_reg <= res_next;
    end

    assign result = res_reg;
    assign done   = done_reg;

endmodule

// File: hdl/pidaw_datapath.sv
`timescale 1ns / 1ps

module pidaw_datapath #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  pidaw_pkg::cfg_t                    cfg,
    input  logic [1:0]                         opcode,
    input  logic signed [pidaw_pkg::WORD_W-1:0] sample_value,
    input  pidaw_pkg::ctrl_cmd_t               cmd,
    output pidaw_pkg::ctrl_stat_t              stat,
    output logic signed [pidaw_pkg::WORD_W-1:0] drive_value,
    output logic signed [pidaw_pkg::WORD_W-1:0] last_measured,
    output logic                               divide_fault
);

    localparam int DW = DATA_WIDTH;
    localparam int OW = pidaw_pkg::WORD_W;
    localparam int XW = ((DW > OW) ? DW : OW) + 2;

    function automatic logic signed [XW-1:0] ext_dw(input logic [DW-1:0] x);
        return {{(XW-DW){x[DW-1]}}, x};
    endfunction

    function automatic logic signed [XW-1:0] ext_32(input logic [OW-1:0] x);
        return {{(XW-OW){x[OW-1]}}, x};
    endfunction

    function automatic logic [DW-1:0] sat_dw(input logic [XW-1:0] v);
        logic [XW-DW:0] hi;
        hi = v[XW-1:DW-1];
        if ((&hi) || !(|hi))
            return v[DW-1:0];
        return v[XW-1] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
    endfunction

    function automatic logic [OW-1:0] sat_32(input logic [XW-1:0] v);
        logic [XW-OW:0] hi;
        hi = v[XW-1:OW-1];
        if ((&hi) || !(|hi))
            return v[OW-1:0];
        return v[XW-1] ? {1'b1, {(OW-1){1'b0}}} : {1'b0, {(OW-1){1'b1}}};
    endfunction

    // architectural state
    logic [DW-1:0] error_now_reg;
    logic [DW-1:0] error_before_reg;
    logic [DW-1:0] integral_reg;
    logic [DW-1:0] deriv_held_reg;
    logic [DW-1:0] measured_reg;

    // per-item working registers
    logic [1:0]    op_reg;
    logic [DW-1:0] val_reg;
    logic          fault_reg;
    logic [DW-1:0] p_reg;
    logic [DW-1:0] i_reg;
    logic [DW-1:0] d_reg;
    logic [DW-1:0] t_reg;
    logic [OW-1:0] drive_reg;
    logic [OW-1:0] last_reg;
    logic          fault_out_reg;

    logic signed [DW-1:0]                mul_a;
    logic signed [pidaw_pkg::GAIN_W-1:0] mul_b;
    logic [DW-1:0]                       mul_res;
    logic                                mul_done;
    logic [DW-1:0]                       div_res;
    logic                                div_done;
    logic signed [XW-1:0]                pid_sum;

    always_comb
    begin
        case (cmd.mul_sel)
            pidaw_pkg::MS_ERR_PERIOD:
            begin
                mul_a = error_now_reg;
                mul_b = {1'b0, cfg.sample_period};
            end
            pidaw_pkg::MS_INT_KI:
            begin
                mul_a = integral_reg;
                mul_b = cfg.integral_gain;
            end
            pidaw_pkg::MS_DER_KD:
            begin
                mul_a = deriv_held_reg;
                mul_b = cfg.deriv_gain;
            end
            pidaw_pkg::MS_T_RATE:
            begin
                mul_a = t_reg;
                mul_b = {1'b0, cfg.sample_rate};
            end
            pidaw_pkg::MS_T_KD:
            begin
                mul_a = t_reg;
                mul_b = cfg.deriv_gain;
            end
            default:
            begin
                mul_a = error_now_reg;
                mul_b = cfg.prop_gain;
            end
        endcase
    end

    pidaw_mul #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_mul (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cmd.mul_start),
        .a      (mul_a),
        .b      (mul_b),
        .result (mul_res),
        .done   (mul_done)
    );

    pidaw_div #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cmd.div_start),
        .num    (t_reg),
        .den    (cfg.integral_gain),
        .result (div_res),
        .done   (div_done)
    );

    assign pid_sum = ext_dw(p_reg) + ext_dw(i_reg) + ext_dw(d_reg);

    // state that the regulator keeps between items
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            error_now_reg    <= '0;
            error_before_reg <= '0;
            integral_reg     <= '0;
            deriv_held_reg   <= '0;
            measured_reg     <= '0;
        end
        else
        begin
            case (cmd.dp_op)
                pidaw_pkg::DP_ERR_UPDATE:
                begin
                    error_before_reg <= error_now_reg;
                    error_now_reg    <= sat_dw(ext_32(cfg.target_setpoint) - ext_dw(val_reg));
                    measured_reg     <= val_reg;
                end
                pidaw_pkg::DP_DERIV_LOAD: deriv_held_reg <= val_reg;
                pidaw_pkg::DP_INT_ACC:
                    integral_reg <= sat_dw(ext_dw(integral_reg) + ext_dw(mul_res));
                pidaw_pkg::DP_INT_DIV:    integral_reg <= div_res;
                default:                  ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.dp_op)
            pidaw_pkg::DP_LOAD:
            begin
                op_reg    <= opcode;
                val_reg   <= sat_dw(ext_32(sample_value));
                fault_reg <= 1'b0;
            end
            pidaw_pkg::DP_FAULT:     fault_reg <= 1'b1;
            pidaw_pkg::DP_NUM_LOAD:  t_reg <= sat_dw(ext_dw(val_reg) - ext_dw(mul_res));
            pidaw_pkg::DP_DIFF_LOAD:
                t_reg <= sat_dw(ext_dw(error_now_reg) - ext_dw(error_before_reg));
            pidaw_pkg::DP_T_STORE:   t_reg <= mul_res;
            pidaw_pkg::DP_P_STORE:   p_reg <= mul_res;
            pidaw_pkg::DP_I_STORE:   i_reg <= mul_res;
            pidaw_pkg::DP_D_STORE:   d_reg <= mul_res;
            pidaw_pkg::DP_OUT_LOAD:
            begin
                drive_reg     <= sat_32(ext_dw(sat_dw(pid_sum)));
                last_reg      <= sat_32(ext_dw(measured_reg));
                fault_out_reg <= fault_reg;
            end
            default: ;
        endcase
    end

    assign stat.opcode     = op_reg;
    assign stat.ki_zero    = (cfg.integral_gain == '0);
    assign stat.deriv_mode = cfg.derivative_mode;
    assign stat.mul_done   = mul_done;
    assign stat.div_done   = div_done;

    assign drive_value   = drive_reg;
    assign last_measured = last_reg;
    assign divide_fault  = fault_out_reg;

endmodule

// File: hdl/pidaw_ctrl.sv
`timescale 1ns / 1ps
`include "pid_controller_anti_windup_core_assert.svh"

module pidaw_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  logic                  out_ready,
    input  pidaw_pkg::ctrl_stat_t stat,
    output pidaw_pkg::ctrl_cmd_t  cmd
);

    typedef enum logic [19:0] {
        S_IDLE     = 20'h00001,
        S_DECODE   = 20'h00002,
        S_INT_MUL  = 20'h00004,
        S_INT_WAIT = 20'h00008,
        S_AW_MUL   = 20'h00010,
        S_AW_WAIT  = 20'h00020,
        S_DIV_GO   = 20'h00040,
        S_DIV_WAIT = 20'h00080,
        S_P_MUL    = 20'h00100,
        S_P_WAIT   = 20'h00200,
        S_I_MUL    = 20'h00400,
        S_I_WAIT   = 20'h00800,
        S_D_MUL    = 20'h01000,
        S_D_WAIT   = 20'h02000,
        S_DIFF     = 20'h04000,
        S_R_MUL    = 20'h08000,
        S_R_WAIT   = 20'h10000,
        S_K_MUL    = 20'h20000,
        S_K_WAIT   = 20'h40000,
        S_OUT      = 20'h80000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next    = state_reg;
        cmd.dp_op     = pidaw_pkg::DP_NONE;
        cmd.mul_start = 1'b0;
        cmd.mul_sel   = pidaw_pkg::MS_ERR_KP;
        cmd.div_start = 1'b0;
        unique case (state_reg)
            S_IDLE:
                if (in_valid)
                begin
                    cmd.dp_op  = pidaw_pkg::DP_LOAD;
                    state_next = S_DECODE;
                end
            S_DECODE:
                unique case (stat.opcode)
                    pidaw_pkg::OPC_MEASURE:
                    begin
                        cmd.dp_op  = pidaw_pkg::DP_ERR_UPDATE;
                        state_next = S_INT_MUL;
                    end
                    pidaw_pkg::OPC_DERIV:
                    begin
                        cmd.dp_op  = pidaw_pkg::DP_DERIV_LOAD;
                        state_next = S_P_MUL;
                    end
                    pidaw_pkg::OPC_LIMIT:
                        if (stat.ki_zero)
                        begin
                            cmd.dp_op  = pidaw_pkg::DP_FAULT;
                            state_next = S_P_MUL;
                        end
                        else
                            state_next = S_AW_MUL;
                    default: state_next = S_P_MUL;
                endcase
            S_INT_MUL:
            begin
                cmd.mul_start = 1'b1;
                cmd.mul_sel   = pidaw_pkg::MS_ERR_PERIOD;
                state_next    = S_INT_WAIT;
            end
            S_INT_WAIT:
                if (stat.mul_done)
                begin
                    cmd.dp_op  = pidaw_pkg::DP_INT_ACC;
                    state_next = S_P_MUL;
                end
            S_AW_MUL:
            begin
                cmd.mul_start = 1'b1;
                cmd.mul_sel   = pidaw_pkg::MS_ERR_KP;
                state_next    = S_AW_WAIT;
            end
            S_AW_WAIT:
                if (stat.mul_done)
                begin
                    cmd.dp_op  = pidaw_pkg::DP_NUM_LOAD;
                    state_next = S_DIV_GO;
                end
            S_DIV_GO:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_DIV_WAIT;
            end
            S_DIV_WAIT:
                if (stat.div_done)
                begin
                    cmd.dp_op  = pidaw_pkg::DP_INT_DIV;
                    state_next = S_P_MUL;
                end
            S_P_MUL:
            begin
                cmd.mul_start = 1'b1;
                cmd.mul_sel   = pidaw_pkg::MS_ERR_KP;
                state_next    = S_P_WAIT;
            end
            S_P_WAIT:
                if (stat.mul_done)
                begin
                    cmd.dp_op  = pidaw_pkg::DP_P_STORE;
                    state_next = S_I_MUL;
                end
            S_I_MUL:
            begin
                cmd.mul_start = 1'b1;
                cmd.mul_sel   = pidaw_pkg::MS_INT_KI;
                state_next    = S_I_WAIT;
            end
            S_I_WAIT:
                if (stat.mul_done)
                begin
                    cmd.dp_op  = pidaw_pkg::DP_I_STORE;
                    state_next = stat.deriv_mode ? S_D_MUL : S_DIFF;
                end
            S_D_MUL:
            begin
                cmd.mul_start = 1'b1;
                cmd.mul_sel   = pidaw_pkg::MS_DER_KD;
                state_next    = S_D_WAIT;
            end
            S_D_WAIT:
                if (stat.mul_done)
                begin
                    cmd.dp_op  = pidaw_pkg::DP_D_STORE;
                    state_next = S_OUT;
                end
            S_DIFF:
            begin
                cmd.dp_op  = pidaw_pkg::DP_DIFF_LOAD;
                state_next = S_R_MUL;
            end
            S_R_MUL:
            begin
                cmd.mul_start = 1'b1;
                cmd.mul_sel   = pidaw_pkg::MS_T_RATE;
                state_next    = S_R_WAIT;
            end
            S_R_WAIT:
                if (stat.mul_done)
                begin
                    cmd.dp_op  = pidaw_pkg::DP_T_STORE;
                    state_next = S_K_MUL;
                end
            S_K_MUL:
            begin
                cmd.mul_start = 1'b1;
                cmd.mul_sel   = pidaw_pkg::MS_T_KD;
                state_next    = S_K_WAIT;
            end
            S_K_WAIT:
                if (stat.mul_done)
                begin
                    cmd.dp_op  = pidaw_pkg::DP_D_STORE;
                    state_next = S_OUT;
                end
            S_OUT:
                // hold until the output register is free or being drained
                if (!out_valid_reg || out_ready)
                begin
                    cmd.dp_op  = pidaw_pkg::DP_OUT_LOAD;
                    state_next = S_IDLE;
                end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        if (cmd.dp_op == pidaw_pkg::DP_OUT_LOAD)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    `PIDAW_ASSERT_IMP(a_mul_done_in_wait, clk, rst_n, stat.mul_done, (state_reg == S_INT_WAIT) || (state_reg == S_AW_WAIT) || (state_reg == S_P_WAIT) || (state_reg == S_I_WAIT) || (state_reg == S_D_WAIT) || (state_reg == S_R_WAIT) || (state_reg == S_K_WAIT))
    `PIDAW_ASSERT_IMP(a_div_done_in_wait, clk, rst_n, stat.div_done, state_reg == S_DIV_WAIT)
    `PIDAW_ASSERT_IMP(a_no_zero_divisor, clk, rst_n, cmd.div_start, !stat.ki_zero)
    `PIDAW_ASSERT_NXT(a_out_load_valid, clk, rst_n, cmd.dp_op == pidaw_pkg::DP_OUT_LOAD, out_valid)

endmodule

// File: hdl/pid_controller_anti_windup_core.sv
`timescale 1ns / 1ps

// Fixed-point PID regulator with anti-windup.
// Input channel (in_valid/in_ready): one word carries opcode and sample_value.
//   Opcode 0 is a measurement, 1 a filtered derivative, 2 an anti-windup limit.
// Output channel (out_valid/out_ready): one word per input word with the
//   saturated drive P+I+D, the last measurement and the divide fault flag.
// Configuration: APB-style port, register i at byte address 4*i, pready tied
//   high; write registers only while no word is in flight.
// Timing: one word at a time through a controller that steps a shared
//   two-digit multiplier and a one-bit-per-cycle divider. A measurement
//   first accumulates error*period into the integral; a limit word with
//   nonzero Ki runs a product and the divider to rebuild the integral;
//   then P, I and D are formed, D from the held derivative or from the
//   error difference. in_ready is high only while the controller is idle,
//   so a word is taken only once the last one's result is loaded out.
// Stall: a finished word waits in the output register; the next word may be
//   accepted and worked on meanwhile, and its result holds until the output
//   register drains.
// Reset: state and history clear to zero, gains to zero, sample rate and
//   period to 1.0; no result is pending.
module pid_controller_anti_windup_core #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    // configuration port
    input  logic                                    psel,
    input  logic                                    penable,
    input  logic                                    pwrite,
    input  logic [pidaw_pkg::CFG_ADDR_W-1:0]        paddr,
    input  logic [pidaw_pkg::WORD_W-1:0]            pwdata,
    output logic [pidaw_pkg::WORD_W-1:0]            prdata,
    output logic                                    pready,
    // input words
    input  logic                                    in_valid,
    output logic                                    in_ready,
    input  logic [1:0]                              opcode,
    input  logic signed [pidaw_pkg::WORD_W-1:0]     sample_value,
    // result words
    output logic                                    out_valid,
    input  logic                                    out_ready,
    output logic signed [pidaw_pkg::WORD_W-1:0]     drive_value,
    output logic signed [pidaw_pkg::WORD_W-1:0]     last_measured,
    output logic                                    divide_fault
);

    pidaw_pkg::cfg_t       cfg_reg;
    pidaw_pkg::ctrl_cmd_t  cmd;
    pidaw_pkg::ctrl_stat_t stat;

    logic [pidaw_pkg::REG_IDX_W-1:0] reg_idx;
    logic                            cfg_write;

    // word-aligned register index; byte lane bits are ignored
    assign reg_idx   = paddr[pidaw_pkg::CFG_ADDR_W-1:2];
    assign cfg_write = psel && penable && pwrite;
    assign pready    = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.prop_gain       <= '0;
            cfg_reg.integral_gain   <= '0;
            cfg_reg.deriv_gain      <= '0;
            cfg_reg.sample_rate     <= pidaw_pkg::RATE_RESET;
            cfg_reg.sample_period   <= pidaw_pkg::PERIOD_RESET;
            cfg_reg.target_setpoint <= '0;
            cfg_reg.derivative_mode <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (reg_idx)
                pidaw_pkg::REG_PROP_GAIN:       cfg_reg.prop_gain <= pwdata;
                pidaw_pkg::REG_INTEGRAL_GAIN:   cfg_reg.integral_gain <= pwdata;
                pidaw_pkg::REG_DERIV_GAIN:      cfg_reg.deriv_gain <= pwdata;
                pidaw_pkg::REG_SAMPLE_RATE:
                    cfg_reg.sample_rate <= pwdata[pidaw_pkg::RATE_W-1:0];
                pidaw_pkg::REG_SAMPLE_PERIOD:
                    cfg_reg.sample_period <= pwdata[pidaw_pkg::RATE_W-1:0];
                pidaw_pkg::REG_TARGET_SETPOINT: cfg_reg.target_setpoint <= pwdata;
                pidaw_pkg::REG_DERIVATIVE_MODE: cfg_reg.derivative_mode <= pwdata[0];
                default: ;  // drop writes to unmapped addresses
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            pidaw_pkg::REG_PROP_GAIN:       prdata = cfg_reg.prop_gain;
            pidaw_pkg::REG_INTEGRAL_GAIN:   prdata = cfg_reg.integral_gain;
            pidaw_pkg::REG_DERIV_GAIN:      prdata = cfg_reg.deriv_gain;
            pidaw_pkg::REG_SAMPLE_RATE:     prdata = {1'b0, cfg_reg.sample_rate};
            pidaw_pkg::REG_SAMPLE_PERIOD:   prdata = {1'b0, cfg_reg.sample_period};
            pidaw_pkg::REG_TARGET_SETPOINT: prdata = cfg_reg.target_setpoint;
            pidaw_pkg::REG_DERIVATIVE_MODE:
                prdata = {{(pidaw_pkg::WORD_W-1){1'b0}}, cfg_reg.derivative_mode};
            default:                        prdata = '0;
        endcase
    end

    pidaw_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    pidaw_datapath #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .opcode        (opcode),
        .sample_value  (sample_value),
        .cmd           (cmd),
        .stat          (stat),
        .drive_value   (drive_value),
        .last_measured (last_measured),
        .divide_fault  (divide_fault)
    );

endmodule
